[rtl/core/qri_pkg.sv]
package qri_pkg;

  localparam int CompW = 16;
  localparam logic signed [CompW-1:0] OneQ14 = 16'sd16384;
  localparam logic [31:0] OneQ28 = 32'd268435456;
  localparam logic [31:0] TolQ28 = 32'd2684354;
  localparam int RegIdxW = 2;
  localparam logic [RegIdxW-1:0] RegRateX = 2'd0;
  localparam logic [RegIdxW-1:0] RegRateY = 2'd1;
  localparam logic [RegIdxW-1:0] RegRateZ = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_INC,
    ST_NORM,
    ST_CHECK,
    ST_SQRT,
    ST_DSTART,
    ST_DIV,
    ST_DSTORE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic inc;
    logic norm;
    logic check;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic div_store;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic need_renorm;
    logic zero_len;
  } stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) return 16'sd32767;
    if (v < -34'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

endpackage

[rtl/core/qri_ctrl.sv]
module qri_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            out_free,
  input  qri_pkg::stat_t  stat,
  output qri_pkg::cmd_t   cmd,
  output logic            busy,
  output logic [5:0]      cnt
);

  qri_pkg::state_t state, state_next;
  logic [5:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qri_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    busy = 1'b1;
    case (state)
      qri_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = qri_pkg::ST_PROD;
        end
      end
      qri_pkg::ST_PROD: begin
        cmd.prod = 1'b1;
        cnt_next = cnt + 6'd1;
        if (stat.last) begin
          cnt_next = '0;
          state_next = qri_pkg::ST_INC;
        end
      end
      qri_pkg::ST_INC: begin
        cmd.inc = 1'b1;
        cnt_next = cnt + 6'd1;
        if (stat.last) begin
          cnt_next = '0;
          state_next = qri_pkg::ST_NORM;
        end
      end
      qri_pkg::ST_NORM: begin
        cmd.norm = 1'b1;
        cnt_next = cnt + 6'd1;
        if (stat.last) begin
          cnt_next = '0;
          state_next = qri_pkg::ST_CHECK;
        end
      end
      qri_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.need_renorm && !stat.zero_len) begin
          cmd.sqrt_start = 1'b1;
          state_next = qri_pkg::ST_SQRT;
        end else begin
          state_next = qri_pkg::ST_DONE;
        end
      end
      qri_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (stat.last) begin
          cnt_next = '0;
          state_next = qri_pkg::ST_DSTART;
        end
      end
      qri_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next = qri_pkg::ST_DIV;
      end
      qri_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 6'd1;
        if (stat.last) begin
          cnt_next = cnt;
          state_next = qri_pkg::ST_DSTORE;
        end
      end
      qri_pkg::ST_DSTORE: begin
        cmd.div_store = 1'b1;
        if (cnt[5:4] == 2'd3) begin
          cnt_next = '0;
          state_next = qri_pkg::ST_DONE;
        end else begin
          cnt_next = {cnt[5:4] + 2'd1, 4'd0};
          state_next = qri_pkg::ST_DSTART;
        end
      end
      qri_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = qri_pkg::ST_IDLE;
        end
      end
      default: state_next = qri_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/core/qri_dp.sv]
module qri_dp (
  input  logic                clk,
  input  logic                rst,
  input  qri_pkg::cmd_t       cmd,
  input  logic [5:0]          cnt,
  input  logic [15:0]         dt_in,
  input  logic signed [15:0]  ra,
  input  logic signed [15:0]  rb,
  input  logic signed [15:0]  rc,
  output qri_pkg::stat_t      stat,
  output logic signed [15:0]  res_w,
  output logic signed [15:0]  res_x,
  output logic signed [15:0]  res_y,
  output logic signed [15:0]  res_z,
  output logic                res_renorm
);

  logic signed [15:0] q [4];
  logic signed [15:0] qn [4];
  logic signed [35:0] p [4];
  logic [15:0] dt;
  logic renorm;
  logic [32:0] n;
  logic [61:0] rad;
  logic [30:0] root;
  logic [31:0] rem;
  logic [33:0] sq_cur;
  logic [34:0] sq_t;
  logic [15:0] num;
  logic [30:0] drem;
  logic [15:0] quo;
  logic [43:0] nume;
  logic [15:0] mag;
  logic [1:0] di;
  logic [1:0] ci, ti;
  logic signed [15:0] ma, mb;
  logic signed [31:0] mprod;
  logic signed [53:0] incp;
  logic signed [33:0] incs;
  logic [32:0] dsub;

  assign ci = cnt[3:2];
  assign ti = cnt[1:0];
  assign di = cnt[5:4];

  always_comb begin
    ma = '0;
    mb = '0;
    case (ci)
      2'd0: begin
        case (ti)
          2'd0: begin ma = qn[1]; mb = -ra; end
          2'd1: begin ma = qn[2]; mb = -rb; end
          2'd2: begin ma = qn[3]; mb = -rc; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      2'd1: begin
        case (ti)
          2'd0: begin ma = qn[0]; mb = ra; end
          2'd1: begin ma = qn[2]; mb = rc; end
          2'd2: begin ma = qn[3]; mb = -rb; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      2'd2: begin
        case (ti)
          2'd0: begin ma = qn[0]; mb = rb; end
          2'd1: begin ma = qn[1]; mb = -rc; end
          2'd2: begin ma = qn[3]; mb = ra; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin
        case (ti)
          2'd0: begin ma = qn[0]; mb = rc; end
          2'd1: begin ma = qn[1]; mb = rb; end
          2'd2: begin ma = qn[2]; mb = -ra; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
    endcase
    if (cmd.norm) begin
      ma = q[cnt[1:0]];
      mb = q[cnt[1:0]];
    end
  end

  // negating -32768 rate: widen before negate
  logic signed [16:0] mbx;
  always_comb begin
    mbx = 17'(mb);
    if (cmd.prod && mb == -16'sd32768 &&
        ((ci == 2'd0) || (ci == 2'd1 && ti == 2'd2) || (ci == 2'd2 && ti == 2'd1) ||
         (ci == 2'd3 && ti == 2'd2)))
      mbx = 17'sd32768;
    mprod = 32'(ma * mbx);
  end

  assign incp = 54'(p[cnt[1:0]]) * $signed({1'b0, dt}) + 54'sd67108864;
  assign incs = 34'(incp >>> 27) + 34'(qn[cnt[1:0]]);
  assign sq_cur = {rem, rad[61:60]};
  assign sq_t = {1'b0, sq_cur} - {2'b0, root, 2'b01};
  assign mag = q[di][15] ? 16'(-q[di]) : q[di];
  assign nume = {mag, 28'd0} + 44'(root >> 1);
  assign dsub = {1'b0, drem, num[15]} - {2'b0, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      qn[0] <= qri_pkg::OneQ14;
      qn[1] <= '0;
      qn[2] <= '0;
      qn[3] <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < 4; i++) qn[i] <= q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt <= dt_in;
      for (int i = 0; i < 4; i++) q[i] <= qn[i];
      renorm <= 1'b0;
      n <= '0;
    end
    if (cmd.prod && ti != 2'd3) begin
      if (ti == 2'd0) p[ci] <= 36'(mprod);
      else p[ci] <= p[ci] + 36'(mprod);
    end
    if (cmd.inc) begin
      q[cnt[1:0]] <= qri_pkg::sat16(incs);
    end
    if (cmd.norm) begin
      n <= n + 33'(mprod);
    end
    if (cmd.check) begin
      renorm <= (n > qri_pkg::OneQ28 + qri_pkg::TolQ28) ||
                (n < qri_pkg::OneQ28 - qri_pkg::TolQ28);
    end
    if (cmd.sqrt_start) begin
      rad <= {1'b0, n, 28'd0};
      root <= '0;
      rem <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[59:0], 2'b00};
      if (!sq_t[34]) begin
        rem <= sq_t[31:0];
        root <= {root[29:0], 1'b1};
      end else begin
        rem <= sq_cur[31:0];
        root <= {root[29:0], 1'b0};
      end
    end
    if (cmd.div_start) begin
      drem <= {3'b0, nume[43:16]};
      num <= nume[15:0];
      quo <= '0;
    end else if (cmd.div_step) begin
      num <= {num[14:0], 1'b0};
      if (!dsub[32]) begin
        drem <= dsub[30:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        drem <= {drem[29:0], num[15]};
        quo <= {quo[14:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      q[di] <= qri_pkg::sat16(q[di][15] ? -34'(quo) : 34'(quo));
    end
  end

  assign stat.last = cmd.prod ? (cnt == 6'd15) :
                     (cmd.inc || cmd.norm) ? (cnt == 6'd3) :
                     cmd.sqrt_step ? (cnt == 6'd30) :
                     cmd.div_step ? (cnt[3:0] == 4'd15) : 1'b0;
  assign stat.need_renorm = (n > qri_pkg::OneQ28 + qri_pkg::TolQ28) ||
                            (n < qri_pkg::OneQ28 - qri_pkg::TolQ28);
  assign stat.zero_len = (n == '0);

  assign res_w = q[0];
  assign res_x = q[1];
  assign res_y = q[2];
  assign res_z = q[3];
  assign res_renorm = cmd.check ? stat.need_renorm : renorm;

endmodule

[rtl/core/quaternion_rate_integrator_core.sv]
// Each tick runs products, increment, length and check; rescaling adds the root and divides.
// Ticks are taken one at a time; the next is taken in the cycle after the result
// register is loaded, which waits until the output is free.
// Cost is set by the shared 16x17 multiplier (products, length), the 31-step
// square root and one 16-step divider run once per component.
// Reset: synchronous, active high; orientation returns to identity, rates to 0.
module quaternion_rate_integrator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic               renormalized
);

  qri_pkg::cmd_t cmd;
  qri_pkg::stat_t stat;
  logic busy;
  logic [5:0] cnt;
  logic signed [15:0] rate_x, rate_y, rate_z;
  logic signed [15:0] rw, rx, ry, rz;
  logic rr, rdy, rflag;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_x <= '0;
      rate_y <= '0;
      rate_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qri_pkg::RegRateX: rate_x <= cfg_data;
        qri_pkg::RegRateY: rate_y <= cfg_data;
        qri_pkg::RegRateZ: rate_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !busy;

  qri_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(in_valid), .out_free(!out_valid || out_ready),
    .stat(stat), .cmd(cmd), .busy(busy), .cnt(cnt)
  );

  qri_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cnt(cnt), .dt_in(time_step),
    .ra(rate_x), .rb(rate_y), .rc(rate_z), .stat(stat),
    .res_w(rw), .res_x(rx), .res_y(ry), .res_z(rz), .res_renorm(rr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rflag <= 1'b0;
    end else if (cmd.check) begin
      rflag <= rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      quat_w <= rw;
      quat_x <= rx;
      quat_y <= ry;
      quat_z <= rz;
      renormalized <= rflag;
    end
  end

  assign rdy = out_valid && !out_ready;

  assert property (@(posedge clk) disable iff (rst) cmd.load |-> in_valid)
    else $error("load without input");
  assert property (@(posedge clk) disable iff (rst) rdy |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> !in_ready || out_valid)
    else $error("commit lost");

endmodule
